// ===== rtl/aswml_pkg.sv =====
// ---------------------------------------------------------------------------
// aswml_pkg
// shared types and constants for the missing-last argsort block
// ---------------------------------------------------------------------------
`default_nettype none

package aswml_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_WIDTH = 64;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;
    localparam logic [1:0] KIND_FLOAT32  = 2'd2;
    localparam logic [1:0] KIND_FLOAT64  = 2'd3;

    localparam logic REG_DESCENDING = 1'b0;
    localparam logic REG_VALUE_KIND = 1'b1;

    typedef struct packed {
        logic [63:0] value;
        logic        is_missing;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [5:0] sorted_index;
        logic [5:0] rank;
        logic       overflow;
        logic       end_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_CMP,
        ST_RD_OUT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       rank_clr;
        logic       rd_i;
        logic       rd_j;
        logic       rank_wr;
        logic       rd_out;
        logic       emit;
        logic       run_clr;
        logic [IDX_W-1:0] i_idx;
        logic [IDX_W-1:0] j_idx;
        logic       last_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } dp_stat_t;

    function automatic logic [63:0] sort_key(input logic [63:0] v, input logic [1:0] kind);
        logic [63:0] w;
        logic [63:0] k;
        w = v;
        k = v;
        case (kind)
            KIND_UNSIGNED: k = v;
            KIND_SIGNED:
            begin
                if (v[VALUE_WIDTH-1])
                begin
                    w = v | ~(64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH));
                end
                k = w ^ 64'h8000_0000_0000_0000;
            end
            KIND_FLOAT32:
            begin
                w = {32'd0, v[31:0]};
                if (w[30:0] == 31'd0)
                begin
                    w = 64'd0;
                end
                k = w[31] ? {32'd0, ~w[31:0]} : (w | 64'h8000_0000);
            end
            default:
            begin
                if (v[62:0] == 63'd0)
                begin
                    w = 64'd0;
                end
                k = w[63] ? ~w : (w | 64'h8000_0000_0000_0000);
            end
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/argsort_with_missing_last.sv =====
// ---------------------------------------------------------------------------
// argsort_with_missing_last
// stable index sort of a loaded data set with missing items last
// ---------------------------------------------------------------------------
// Elements load one per cycle while busy is low. After the element marked
// last, the block counts for each stored item how many items go before it,
// one comparison per cycle. The N results then come out on consecutive
// cycles with result_valid, and busy drops right after the final result.
// The receiver cannot stall; every result is shown for a single cycle.
`default_nettype none

module argsort_with_missing_last
    import aswml_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_item_t  in_item,
    output logic           result_valid,
    output out_item_t      result,
    input  wire logic      cfg_we,
    input  wire logic      cfg_index,
    input  wire logic [1:0] cfg_data
);

    logic       descending_reg;
    logic [1:0] value_kind_reg;
    logic       start_ok;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
            value_kind_reg <= KIND_SIGNED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DESCENDING: descending_reg <= cfg_data[0];
                REG_VALUE_KIND: value_kind_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    aswml_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_last (in_item.last),
        .stat       (stat),
        .busy       (busy),
        .start_ok   (start_ok),
        .cmd        (cmd)
    );

    aswml_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .start_ok     (start_ok),
        .descending   (descending_reg),
        .value_kind   (value_kind_reg),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

// ===== rtl/aswml_datapath.sv =====
// ---------------------------------------------------------------------------
// aswml_datapath
// element store, key compare, rank counting and order table
// ---------------------------------------------------------------------------
`default_nettype none

module aswml_datapath
    import aswml_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_item,
    input  wire logic      start_ok,
    input  wire logic      descending,
    input  wire logic [1:0] value_kind,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    output out_item_t      result,
    output logic           result_valid
);

    logic [VALUE_WIDTH-1:0] val_mem [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]   miss_reg;
    logic [IDX_W-1:0]       ord_mem [MAX_ITEMS];
    logic [IDX_W-1:0]       rank_mem [MAX_ITEMS];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [63:0]            ki_reg;
    logic                   mi_reg;
    logic [63:0]            kj_rd_reg;
    logic                   mj_rd_reg;
    logic [IDX_W-1:0]       jd_reg, id_reg;
    logic                   jv_reg;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       ord_rd_reg, rank_rd_reg;
    logic                   last_d_reg, emit_d_reg;
    logic                   j_first;
    logic                   full;

    assign full = count_reg == CNT_W'(MAX_ITEMS);

    always_ff @(posedge clk)
    begin
        if (start_ok && !full)
        begin
            val_mem[count_reg[IDX_W-1:0]] <= in_item.value[VALUE_WIDTH-1:0];
            miss_reg[count_reg[IDX_W-1:0]] <= in_item.is_missing;
        end
        if (cmd.rd_i)
        begin
            ki_reg <= sort_key(64'(val_mem[cmd.i_idx]), value_kind);
            mi_reg <= miss_reg[cmd.i_idx];
        end
        if (cmd.rd_j)
        begin
            kj_rd_reg <= sort_key(64'(val_mem[cmd.j_idx]), value_kind);
            mj_rd_reg <= miss_reg[cmd.j_idx];
        end
        jd_reg <= cmd.j_idx;
        id_reg <= cmd.i_idx;
        if (cmd.rank_wr)
        begin
            rank_mem[id_reg] <= cnt_next;
            ord_mem[cnt_next] <= id_reg;
        end
        if (cmd.rd_out)
        begin
            ord_rd_reg  <= ord_mem[cmd.i_idx];
            rank_rd_reg <= rank_mem[cmd.i_idx];
        end
        last_d_reg <= cmd.last_out;
    end

    always_comb
    begin
        if (mj_rd_reg != mi_reg)
        begin
            j_first = mi_reg;
        end
        else if (!mi_reg && kj_rd_reg != ki_reg)
        begin
            j_first = descending ? (kj_rd_reg > ki_reg) : (kj_rd_reg < ki_reg);
        end
        else
        begin
            j_first = jd_reg < id_reg;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.rank_clr)
        begin
            cnt_next = '0;
        end
        else if (jv_reg && j_first && jd_reg != id_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (start_ok)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.run_clr)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= '0;
            jv_reg     <= 1'b0;
            emit_d_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            cnt_reg    <= cnt_next;
            jv_reg     <= cmd.rd_j;
            emit_d_reg <= cmd.emit;
        end
    end

    assign stat.count = count_next;
    assign result_valid        = emit_d_reg;
    assign result.sorted_index = 6'(ord_rd_reg);
    assign result.rank         = 6'(rank_rd_reg);
    assign result.overflow     = ovf_reg;
    assign result.end_of_run   = last_d_reg;

endmodule

`default_nettype wire

// ===== rtl/aswml_ctrl.sv =====
// ---------------------------------------------------------------------------
// aswml_ctrl
// sequencer for load, pairwise rank count and result output
// ---------------------------------------------------------------------------
`default_nettype none

module aswml_ctrl
    import aswml_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     start_last,
    input  wire dp_stat_t stat,
    output logic          busy,
    output logic          start_ok,
    output dp_cmd_t       cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.i_idx  = i_reg[IDX_W-1:0];
        cmd.j_idx  = j_reg[IDX_W-1:0];
        busy       = 1'b1;
        start_ok   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                busy     = 1'b0;
                start_ok = start;
                if (start && start_last)
                begin
                    n_next     = stat.count;
                    i_next     = '0;
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I:
            begin
                cmd.rd_i     = 1'b1;
                cmd.rank_clr = 1'b1;
                j_next       = '0;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                if (j_reg < n_reg)
                begin
                    cmd.rd_j = 1'b1;
                    j_next   = j_reg + 1'b1;
                end
                else
                begin
                    cmd.rank_wr = 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        i_next     = '0;
                        state_next = ST_RD_OUT;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_RD_I;
                    end
                end
            end
            ST_RD_OUT:
            begin
                cmd.rd_out   = 1'b1;
                cmd.emit     = 1'b1;
                cmd.last_out = (i_reg + 1'b1 == n_reg);
                if (i_reg + 1'b1 == n_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                // final result is on the ports, clear the run afterwards
                cmd.run_clr = 1'b1;
                state_next  = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/aswml_checker.sv =====
// ---------------------------------------------------------------------------
// aswml_checker
// port-level checks on the argsort block
// ---------------------------------------------------------------------------
`default_nettype none

module aswml_checker
    import aswml_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire in_item_t  in_item,
    input wire logic      result_valid,
    input wire out_item_t result
);

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy || $past(busy))
        else $error("result while idle");

    a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_run |=> !busy)
        else $error("block stays busy after end of run");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && in_item.last |=> busy)
        else $error("no sort after last");

    a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(result_valid) && !$past(result.end_of_run)
        |-> $stable(result.overflow))
        else $error("overflow changes within a run");

endmodule

bind argsort_with_missing_last aswml_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

// ===== dv/argsort_with_missing_last_checker.sv =====
// ---------------------------------------------------------------------------
// argsort_with_missing_last_checker
// watches the load and result channels, predicts each sorted run and compares
// ---------------------------------------------------------------------------
// Accepted elements fill a local copy of the data set, up to MAX_ITEMS. When
// the element marked last is accepted, a stable rank count (missing items
// last) is computed under the current configuration and the expected results
// are queued. Each result strobe is compared with the oldest queued result.
`default_nettype none

module argsort_with_missing_last_checker
    import aswml_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire in_item_t   in_item,
    input  wire logic       result_valid,
    input  wire out_item_t  result,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [1:0] cfg_data,
    output int              fail_count,
    output int              pending
);

    logic [63:0] held_values [MAX_ITEMS];
    logic        held_missing [MAX_ITEMS];
    int          held_count;
    logic        dropped;
    logic        sort_desc;
    logic [1:0]  sort_kind;
    out_item_t   expected_results [$];

    assign pending = expected_results.size();

    function automatic logic [63:0] order_key(input logic [63:0] v, input logic [1:0] kind);
        logic [63:0] w;
        case (kind)
            KIND_UNSIGNED: return v;
            KIND_SIGNED: return v ^ 64'h8000_0000_0000_0000;
            KIND_FLOAT32:
            begin
                w = {32'd0, v[31:0]};
                if (w[30:0] == 31'd0)
                begin
                    w = 64'd0;
                end
                if (w[31])
                begin
                    return {32'd0, ~w[31:0]};
                end
                return {32'd0, 1'b1, w[30:0]};
            end
            default:
            begin
                w = v;
                if (w[62:0] == 63'd0)
                begin
                    w = 64'd0;
                end
                if (w[63])
                begin
                    return ~w;
                end
                return {1'b1, w[62:0]};
            end
        endcase
    endfunction

    task automatic predict_sorted_run();
        logic [63:0] keys [MAX_ITEMS];
        int          ranks [MAX_ITEMS];
        int          by_rank [MAX_ITEMS];
        bit          ahead;
        out_item_t   r;
        for (int i = 0; i < held_count; i++)
        begin
            keys[i] = order_key(held_values[i], sort_kind);
        end
        for (int i = 0; i < held_count; i++)
        begin
            ranks[i] = 0;
            for (int j = 0; j < held_count; j++)
            begin
                if (j == i)
                begin
                    continue;
                end
                if (held_missing[j] != held_missing[i])
                begin
                    ahead = held_missing[i];
                end
                else if (!held_missing[j] && keys[j] != keys[i])
                begin
                    ahead = sort_desc ? (keys[j] > keys[i]) : (keys[j] < keys[i]);
                end
                else
                begin
                    ahead = (j < i);
                end
                if (ahead)
                begin
                    ranks[i]++;
                end
            end
            by_rank[ranks[i]] = i;
        end
        for (int k = 0; k < held_count; k++)
        begin
            r.sorted_index = by_rank[k][5:0];
            r.rank         = ranks[k][5:0];
            r.overflow     = dropped;
            r.end_of_run   = (k + 1 == held_count);
            expected_results.push_back(r);
        end
        held_count = 0;
        dropped    = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            held_count = 0;
            dropped    = 1'b0;
            sort_desc  = 1'b0;
            sort_kind  = KIND_SIGNED;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result transfer: %p", result);
                    end
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.sorted_index !== result.sorted_index || e.rank !== result.rank
                        || e.overflow !== result.overflow
                        || e.end_of_run !== result.end_of_run)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result mismatch: expected %p, got %p", e, result);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_DESCENDING)
                begin
                    sort_desc = cfg_data[0];
                end
                else
                begin
                    sort_kind = cfg_data;
                end
            end
            if (start && !busy)
            begin
                if (held_count < MAX_ITEMS)
                begin
                    held_values[held_count]  = in_item.value;
                    held_missing[held_count] = in_item.is_missing;
                    held_count++;
                end
                else
                begin
                    dropped = 1'b1;
                end
                if (in_item.last)
                begin
                    predict_sorted_run();
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/argsort_with_missing_last_tb.sv =====
// ---------------------------------------------------------------------------
// argsort_with_missing_last_tb
// stimulus and verdict for the missing-last argsort block
// ---------------------------------------------------------------------------
// Loads data sets of mostly small sizes with ties, missing items, float
// corner values and overflowing sets, through every value kind and sort
// direction, with random start gaps. Checking is done by the checker module.
`default_nettype none

module argsort_with_missing_last_tb;
    import aswml_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   in_item;
    logic       result_valid;
    out_item_t  result;
    logic       cfg_we;
    logic       cfg_index;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending;
    int         gap_pct;

    argsort_with_missing_last dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    argsort_with_missing_last_checker sorted_run_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one element transfer, with a random gap before it
    task automatic load_element(input logic [63:0] v, input logic m, input logic l);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= '{value: v, is_missing: m, last: l};
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait for a run to drain before touching the registers
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_value(input logic [1:0] kind);
        logic [63:0] corner [10];
        corner = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000, 64'h7F80_0000,
                   64'hFF80_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                   64'h1};
        case ($urandom_range(3))
            0: return corner[$urandom_range(9)];
            1: return {32'd0, $urandom_range(3)};
            2: return (kind == KIND_FLOAT32) ? {$urandom, $urandom_range(1) ? 32'h3F80_0000
                       : 32'hBF80_0000 | $urandom_range(7)} : {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic load_set(input int n, input logic [1:0] kind);
        for (int i = 0; i < n; i++)
        begin
            load_element(pick_value(kind), $urandom_range(5) == 0, i == n - 1);
        end
    endtask

    initial
    begin
        #400000;
        $display("FAIL argsort_with_missing_last");
        $finish;
    end

    initial
    begin
        int sent;
        int n;
        logic [1:0] kind;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_DESCENDING;
        cfg_data  = 2'd0;
        gap_pct   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, single element, ties, missing, zeros
        load_element(64'h5, 1'b0, 1'b1);
        drain();
        load_element(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        load_element(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        load_element(64'h0, 1'b0, 1'b0);
        load_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        load_element(64'h0, 1'b0, 1'b0);
        load_element(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
        drain();
        write_reg(REG_VALUE_KIND, KIND_FLOAT64);
        write_reg(REG_DESCENDING, 2'd1);
        load_element(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        load_element(64'h0, 1'b0, 1'b0);
        load_element(64'hFFF0_0000_0000_0000, 1'b0, 1'b0);
        load_element(64'h7FF8_0000_0000_0000, 1'b0, 1'b0);
        load_element(64'hFFF8_0000_0000_0000, 1'b0, 1'b0);
        load_element(64'h3FF0_0000_0000_0000, 1'b1, 1'b1);
        drain();
        write_reg(REG_VALUE_KIND, KIND_FLOAT32);
        load_element(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
        load_element(64'h0, 1'b0, 1'b0);
        load_element(64'hFF80_0000, 1'b0, 1'b0);
        load_element(64'h7F80_0000, 1'b1, 1'b0);
        load_element(64'h7F80_0000, 1'b0, 1'b1);
        drain();
        // overflow: full store then a dropped last element
        write_reg(REG_VALUE_KIND, KIND_UNSIGNED);
        write_reg(REG_DESCENDING, 2'd0);
        for (int i = 0; i < MAX_ITEMS + 2; i++)
        begin
            load_element({$urandom, $urandom}, 1'b0, i == MAX_ITEMS + 1);
        end
        drain();

        sent = 0;
        while (sent < 150)
        begin
            kind = 2'($urandom_range(3));
            write_reg(REG_VALUE_KIND, kind);
            write_reg(REG_DESCENDING, 2'($urandom_range(1)));
            gap_pct = ($urandom_range(4) == 0) ? 0 : 35;
            n = ($urandom_range(9) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 3)
                : $urandom_range(1, 8);
            load_set(n, kind);
            sent += n;
            drain();
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS argsort_with_missing_last");
        end
        else
        begin
            $display("FAIL argsort_with_missing_last");
        end
        $finish;
    end

endmodule

`default_nettype wire
